// ----- rtl/core/dht_pkg.sv -----
// Package for the double hash key table.
// Holds the sequencer states, result codes, slot layout and hash constants.
// No dependencies.
package dht_pkg;

	localparam int unsigned DefSlotCount = 1024;

	localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;
	localparam logic [63:0] StrideSalt = 64'h517cc1b727220a95;

	localparam int unsigned FieldW = 11;
	localparam int unsigned IdW = 31;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIX,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef enum logic [2:0] {
		RES_NEW = 3'd0,
		RES_DUP = 3'd1,
		RES_CAP = 3'd2,
		RES_FULL = 3'd3,
		RES_REJECT = 3'd4,
		RES_HIT = 3'd5,
		RES_MISS = 3'd6
	} result_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic {
		CFG_MAX_ENTRIES = 1'b0,
		CFG_LOOKUP_PHASE = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		MS_SHIFT30 = 4'd0,
		MS_A_LL = 4'd1,
		MS_A_LH = 4'd2,
		MS_A_HL = 4'd3,
		MS_SHIFT27 = 4'd4,
		MS_B_LL = 4'd5,
		MS_B_LH = 4'd6,
		MS_B_HL = 4'd7,
		MS_SHIFT31 = 4'd8
	} mix_step_t;

	typedef struct packed {
		logic [63:0] primary;
		logic [31:0] check;
		logic        exact;
		logic [30:0] id;
	} slot_t;

endpackage

// ----- rtl/core/double_hash_key_table.sv -----
// Double hash key table: an open-addressing table of 96-bit keys with ids, built on dht_pkg.
// A rejected item gives its result without leaving idle. Any other item first runs the two hashes
// in turn on one shared 32x32 multiplier, then passes a read state and a check state per slot examined.
// Busy stays high until the result, so the block takes a new item only once the last one is
// through; a rejected item never raises busy. The done strobe lasts one cycle; the receiver
// cannot stall. After reset a clearing pass over every slot runs with busy high.
module double_hash_key_table
	import dht_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = DefSlotCount
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [63:0]         key_primary,
	input  logic [31:0]         key_check,
	input  logic [IdW-1:0]      hint_id,
	input  logic                exact_flag,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [FieldW-1:0]   cfg_data,
	output logic                done,
	output logic [2:0]          status,
	output logic [IdW-1:0]      found_id,
	output logic [FieldW-1:0]   probe_count,
	output logic [FieldW-1:0]   entry_count
);

	localparam int unsigned IW = $clog2(SLOT_COUNT);
	localparam int unsigned CW = IW + 1;
	localparam int unsigned CMPW = (CW > FieldW) ? CW : FieldW;
	localparam int unsigned LoadLimit = (4 * SLOT_COUNT + 4) / 5 - 1;

	slot_t mem [SLOT_COUNT];
	slot_t rd_q;

	state_t state_q, state_d;
	mix_step_t step_q;
	logic mix_sel_q;

	logic [FieldW-1:0] max_entries_q;
	logic lookup_phase_q;

	logic [IW-1:0] clr_q, pos_q, stride_q;
	logic [CW-1:0] probes_q, occ_q;
	logic [63:0] v_q, acc_q;

	logic op_q, exact_q;
	logic [63:0] kp_q;
	logic [31:0] kc_q;
	logic [IdW-1:0] id_q;

	logic done_q;
	result_t status_q;
	logic [IdW-1:0] found_q;
	logic [CW-1:0] probe_out_q, entry_out_q;

	logic [63:0] kp_in;
	logic reject;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] mix_out;
	logic [CW-1:0] cnt;
	logic is_empty, is_match, exhausted, finish, better, cap_hit, load_hit;
	logic we;
	logic [IW-1:0] waddr;
	slot_t wdata;
	logic [31:0] probe_ext, entry_ext;

	assign kp_in = (key_primary == 64'd0) ? 64'd1 : key_primary;
	assign reject = (operation != lookup_phase_q) ||
		(operation == OP_INSERT && hint_id == '0);

	always_comb begin
		case (step_q)
			MS_A_LL, MS_B_LL, MS_A_LH, MS_B_LH: mul_a = v_q[31:0];
			default: mul_a = v_q[63:32];
		endcase
		case (step_q)
			MS_A_LL, MS_A_HL: mul_b = MixMulA[31:0];
			MS_A_LH: mul_b = MixMulA[63:32];
			MS_B_LL, MS_B_HL: mul_b = MixMulB[31:0];
			default: mul_b = MixMulB[63:32];
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);
	assign mix_out = acc_q ^ (acc_q >> 31);

	assign cnt = probes_q + CW'(1);
	assign is_empty = (rd_q.primary == 64'd0);
	assign is_match = (rd_q.primary == kp_q) && (rd_q.check == kc_q);
	assign exhausted = (cnt == CW'(SLOT_COUNT));
	assign finish = is_empty || is_match || exhausted;
	assign better = (exact_q && !rd_q.exact) || ((exact_q == rd_q.exact) && (id_q < rd_q.id));
	assign cap_hit = !exact_q && (CMPW'(occ_q) >= CMPW'(max_entries_q));
	assign load_hit = !is_empty || (occ_q >= CW'(LoadLimit));

	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = '{primary: kp_q, check: kc_q, exact: exact_q, id: id_q};
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_CHECK: begin
				if (op_q == OP_INSERT) begin
					if (is_match) begin
						we = better;
						wdata.primary = rd_q.primary;
						wdata.check = rd_q.check;
					end else if (finish) begin
						we = !cap_hit && !load_hit;
					end
				end
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == IW'(SLOT_COUNT - 1)) state_d = ST_IDLE;
			ST_IDLE: if (start && !reject) state_d = ST_MIX;
			ST_MIX: if (step_q == MS_SHIFT31 && mix_sel_q) state_d = ST_READ;
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: state_d = finish ? ST_IDLE : ST_READ;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			occ_q <= '0;
			max_entries_q <= FieldW'(1024);
			lookup_phase_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= MS_SHIFT30;
			mix_sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MAX_ENTRIES: max_entries_q <= cfg_data;
					default: lookup_phase_q <= cfg_data[0];
				endcase
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + IW'(1);
				ST_IDLE: begin
					if (start) begin
						step_q <= MS_SHIFT30;
						mix_sel_q <= 1'b0;
						if (reject) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_MIX: begin
					if (step_q == MS_SHIFT31) begin
						step_q <= MS_SHIFT30;
						mix_sel_q <= 1'b1;
					end else begin
						step_q <= mix_step_t'(step_q + 4'd1);
					end
				end
				ST_CHECK: begin
					if (finish) begin
						done_q <= 1'b1;
						if (!is_match && op_q == OP_INSERT && !cap_hit && !load_hit) begin
							occ_q <= occ_q + CW'(1);
						end
					end
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q <= operation;
					kp_q <= kp_in;
					kc_q <= key_check;
					id_q <= hint_id;
					exact_q <= exact_flag;
					v_q <= kp_in ^ {32'd0, key_check};
					status_q <= RES_REJECT;
					found_q <= '0;
					probe_out_q <= '0;
					entry_out_q <= occ_q;
				end
			end
			ST_MIX: begin
				case (step_q)
					MS_SHIFT30: v_q <= v_q ^ (v_q >> 30);
					MS_A_LL, MS_B_LL: acc_q <= prod;
					MS_A_LH, MS_A_HL, MS_B_LH, MS_B_HL: acc_q <= acc_q + {prod[31:0], 32'd0};
					MS_SHIFT27: v_q <= acc_q ^ (acc_q >> 27);
					default: begin
						if (!mix_sel_q) begin
							pos_q <= mix_out[IW-1:0];
							v_q <= kp_q + {kc_q, 32'd0} + StrideSalt;
						end else begin
							stride_q <= mix_out[IW-1:0] | IW'(1);
							probes_q <= '0;
						end
					end
				endcase
			end
			ST_CHECK: begin
				probes_q <= cnt;
				probe_out_q <= cnt;
				found_q <= '0;
				entry_out_q <= occ_q;
				if (is_match) begin
					if (op_q == OP_LOOKUP) begin
						status_q <= RES_HIT;
						found_q <= rd_q.id;
					end else begin
						status_q <= RES_DUP;
					end
				end else if (finish) begin
					if (op_q == OP_LOOKUP) begin
						status_q <= RES_MISS;
					end else if (cap_hit) begin
						status_q <= RES_CAP;
					end else if (load_hit) begin
						status_q <= RES_FULL;
					end else begin
						status_q <= RES_NEW;
						entry_out_q <= occ_q + CW'(1);
					end
				end else begin
					pos_q <= pos_q + stride_q;
				end
			end
			default: status_q <= status_q;
		endcase
	end

	assign probe_ext = 32'(probe_out_q);
	assign entry_ext = 32'(entry_out_q);

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign status = status_q;
	assign found_id = found_q;
	assign probe_count = probe_ext[FieldW-1:0];
	assign entry_count = entry_ext[FieldW-1:0];

endmodule
